// ----- design/atg_pkg.sv -----
// Shared constants and elaboration-time helpers for the ACES tone map pixel core.
package atg_pkg;

  // Default gamma table resolution in bits.
  localparam int unsigned GammaBitsDef = 12;

  // Scaled radiance is unsigned 4.16 after saturation at 8.0.
  localparam int unsigned XW = 20;
  localparam logic [XW-1:0] XSat = 20'h80000;

  // Width of the curve numerator and denominator.
  localparam int unsigned NumW = 47;

  // Configuration register indexes.
  localparam logic [0:0] RegExposure = 1'b0;
  localparam logic [0:0] RegScale    = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [15:0] ExposureRst = 16'd256;
  localparam logic [15:0] ScaleRst    = 16'd1024;

  // Integer power in a wide word, used only at elaboration.
  function automatic logic [191:0] big_pow(int unsigned base, int unsigned n);
    logic [191:0] acc;
    acc = 192'd1;
    for (int k = 0; k < n; k++) begin
      acc = acc * 192'(base);
    end
    return acc;
  endfunction

  // Smallest code q with q^5 * 510^11 >= m^5 * (2b-1)^11, or m+1 when none.
  function automatic logic [16:0] gamma_thresh(int unsigned b, int unsigned m);
    logic [191:0] rhs;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    rhs = big_pow(m, 5) * big_pow(2 * b - 1, 11);
    lo  = 0;
    hi  = m + 1;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (big_pow(mid, 5) * big_pow(510, 11) >= rhs) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return 17'(lo);
  endfunction

endpackage

// ----- design/atg_gamma.sv -----
// Pipelined gamma encoder: an eight step threshold search that yields one byte.
module atg_gamma #(
  parameter int unsigned GAMMA_TABLE_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [GAMMA_TABLE_BITS-1:0] q_i,
  output logic [7:0]                  byte_o
);
  import atg_pkg::*;

  localparam int unsigned GTB = GAMMA_TABLE_BITS;
  localparam int unsigned M   = (1 << GTB) - 1;

  // Threshold per byte value; a code at or above it reaches that byte.
  logic [GTB:0] thr [256];

  for (genvar gi = 0; gi < 256; gi++) begin : g_thr
    if (gi == 0) begin : g_zero
      assign thr[gi] = '0;
    end else begin : g_val
      localparam logic [16:0] T = gamma_thresh(gi, M);
      assign thr[gi] = T[GTB:0];
    end
  end

  logic [GTB-1:0] q_q [7];
  logic [7:0]     b_q [8];

  // One result bit per stage, most significant first.
  for (genvar j = 0; j < 8; j++) begin : g_stage
    localparam logic [7:0] Bit = 8'(1 << (7 - j));
    logic [GTB-1:0] q_in;
    logic [7:0]     b_in;
    logic [7:0]     cand;

    if (j == 0) begin : g_first
      assign q_in = q_i;
      assign b_in = '0;
    end else begin : g_next
      assign q_in = q_q[j-1];
      assign b_in = b_q[j-1];
    end

    assign cand = b_in | Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        b_q[j] <= ({1'b0, q_in} >= thr[cand]) ? cand : b_in;
      end
    end

    if (j < 7) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          q_q[j] <= q_in;
        end
      end
    end
  end

  assign byte_o = b_q[7];

endmodule

// ----- design/atg_lane.sv -----
// One color lane: exposure scaling, ACES curve, quantizing divider and gamma.
module atg_lane #(
  parameter int unsigned GAMMA_TABLE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] sum_i,
  input  logic [15:0] exposure_i,
  input  logic [15:0] scale_i,
  output logic [7:0]  byte_o
);
  import atg_pkg::*;

  localparam int unsigned GTB = GAMMA_TABLE_BITS;
  localparam int unsigned M   = (1 << GTB) - 1;
  localparam int unsigned RW  = NumW + GTB;

  logic [47:0]     p1_q;
  logic [63:0]     p2;
  logic [XW-1:0]   x_d, x_q, x3_q;
  logic [27:0]     a_q, b_q;
  logic [NumW-1:0] num_q, den_q, d5_q;
  logic [RW-1:0]   n5_q;
  logic            sat5_q;

  // Sum times sample scale.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= 48'(sum_i) * 48'(scale_i);
    end
  end

  // Times exposure, keep 16 fraction bits and saturate at 8.0.
  assign p2  = 64'(p1_q) * 64'(exposure_i);
  assign x_d = (p2[63:24] > 40'(XSat)) ? XSat : p2[43:24];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
    end
  end

  // Inner linear terms of the curve.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x3_q <= x_q;
      a_q  <= 28'd251 * 28'(x_q) + 28'(32'd3 << 16);
      b_q  <= 28'd243 * 28'(x_q) + 28'(32'd59 << 16);
    end
  end

  // Numerator and denominator of the curve.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= NumW'(x3_q) * NumW'(a_q);
      den_q <= NumW'(x3_q) * NumW'(b_q) + NumW'(64'd14 << 32);
    end
  end

  // Scaled numerator with half the divisor added for rounding.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat5_q <= (num_q >= den_q);
      n5_q   <= RW'(num_q) * RW'(M) + RW'(den_q >> 1);
      d5_q   <= den_q;
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic [RW-1:0]   rem_q [GTB-1];
  logic [NumW-1:0] dd_q  [GTB-1];
  logic [GTB-1:0]  qb_q  [GTB];
  logic            sat_q [GTB];

  for (genvar s = 0; s < GTB; s++) begin : g_div
    localparam int unsigned K = GTB - 1 - s;
    localparam logic [GTB-1:0] QBit = GTB'(1 << K);
    logic [RW-1:0]   r_in;
    logic [NumW-1:0] d_in;
    logic [GTB-1:0]  qb_in;
    logic            sat_in;
    logic [RW-1:0]   shifted;
    logic            fits;

    if (s == 0) begin : g_first
      assign r_in   = n5_q;
      assign d_in   = d5_q;
      assign qb_in  = '0;
      assign sat_in = sat5_q;
    end else begin : g_next
      assign r_in   = rem_q[s-1];
      assign d_in   = dd_q[s-1];
      assign qb_in  = qb_q[s-1];
      assign sat_in = sat_q[s-1];
    end

    assign shifted = RW'(d_in) << K;
    assign fits    = (r_in >= shifted);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qb_q[s]  <= fits ? (qb_in | QBit) : qb_in;
        sat_q[s] <= sat_in;
      end
    end

    if (s < GTB - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= fits ? (r_in - shifted) : r_in;
          dd_q[s]  <= d_in;
        end
      end
    end
  end

  // A curve value at or above one maps to full scale.
  logic [GTB-1:0] q_fin;
  assign q_fin = sat_q[GTB-1] ? GTB'(M) : qb_q[GTB-1];

  atg_gamma #(
    .GAMMA_TABLE_BITS(GTB)
  ) u_gamma (
    .clk_i (clk_i),
    .en_i  (en_i),
    .q_i   (q_fin),
    .byte_o(byte_o)
  );

endmodule

// ----- design/aces_tonemap_gamma_pixel_core.sv -----
// Top level of the ACES tone map and gamma encoder, three lanes and a merged output.
//
// Usage: one pixel item of three 16.16 radiance sums enters on the input
// channel (in_valid_i / in_ready_o) and one item of three gamma encoded
// bytes leaves on the output channel (out_valid_o / out_ready_i).
// Exposure gain (8.8) and sample scale (0.16) are set through the write
// port; the user must write them only while the block is idle, as the
// block itself does not enforce it. The pipeline has five arithmetic
// stages, one divider stage per quotient bit and eight gamma search stages.
// Throughput is one pixel per cycle while the output is not stalled; all
// three channels run in parallel lanes that share one stall enable.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops
// while a result waits; in_ready_o is high whenever no result is stalled.
// Reset clears all pipeline valid bits and loads exposure 1.0 and a
// sample scale of 1024.
module aces_tonemap_gamma_pixel_core #(
  parameter int unsigned GAMMA_TABLE_BITS = atg_pkg::GammaBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] red_sum_i,
  input  logic [31:0] green_sum_i,
  input  logic [31:0] blue_sum_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_byte_o,
  output logic [7:0]  green_byte_o,
  output logic [7:0]  blue_byte_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import atg_pkg::*;

  localparam int unsigned Lat = 13 + GAMMA_TABLE_BITS;

  logic [15:0]    exposure_q, scale_q;
  logic [Lat-1:0] vld_q, vld_d;
  logic           en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exposure_q <= ExposureRst;
      scale_q    <= ScaleRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegExposure: exposure_q <= cfg_data_i;
        RegScale:    scale_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // The pipeline advances unless a finished item is stalled at the output.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  assign vld_d = {vld_q[Lat-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q[Lat-1];

  // Three color lanes.
  atg_lane #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_red (
    .clk_i(clk_i), .en_i(en), .sum_i(red_sum_i),
    .exposure_i(exposure_q), .scale_i(scale_q), .byte_o(red_byte_o)
  );

  atg_lane #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_green (
    .clk_i(clk_i), .en_i(en), .sum_i(green_sum_i),
    .exposure_i(exposure_q), .scale_i(scale_q), .byte_o(green_byte_o)
  );

  atg_lane #(.GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)) u_blue (
    .clk_i(clk_i), .en_i(en), .sum_i(blue_sum_i),
    .exposure_i(exposure_q), .scale_i(scale_q), .byte_o(blue_byte_o)
  );

endmodule

// ----- design/atg_checker.sv -----
// Port level checks for the tone map core and their binding to the top level.
module atg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_byte_o,
  input logic [7:0] green_byte_o,
  input logic [7:0] blue_byte_o
);

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // A stalled result keeps its bytes.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(red_byte_o) && $stable(green_byte_o) && $stable(blue_byte_o))
    else $error("output item changed while stalled");

  // A stalled result holds back the input side.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // With no result waiting the block always takes an item.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready with empty output");

endmodule

bind aces_tonemap_gamma_pixel_core atg_checker u_atg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_byte_o  (red_byte_o),
  .green_byte_o(green_byte_o),
  .blue_byte_o (blue_byte_o)
);

// ----- tb/sv/aces_tonemap_gamma_pixel_core_test.sv -----
// Self-checking testbench for the ACES tone map and gamma pixel core.
`timescale 1ns / 100ps

module aces_tonemap_gamma_pixel_core_test;
  import atg_pkg::*;

  localparam int unsigned TableBits = 12;
  localparam int unsigned CodeMax   = (1 << TableBits) - 1;
  localparam int unsigned DrainWait = 40;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_bytes_t;

  // Predicts the output bytes of each accepted pixel and checks results in order.
  class pixel_scoreboard;
    logic [15:0]  gain;
    logic [15:0]  scale;
    logic [7:0]   gamma_lut[CodeMax+1];
    pixel_bytes_t pending_q[$];
    int unsigned  fail_count;

    function new();
      int unsigned b;
      gain       = ExposureRst;
      scale      = ScaleRst;
      fail_count = 0;
      // Byte codes rise with q, so one sweep fills the gamma table.
      b = 0;
      for (int unsigned q = 0; q <= CodeMax; q++) begin
        while (b < 255 && gamma_reached(q, b + 1)) begin
          b++;
        end
        gamma_lut[q] = 8'(b);
      end
    endfunction

    // Exact test of q^5 * 510^11 against M^5 * (2b-1)^11.
    function bit gamma_reached(int unsigned q, int unsigned b);
      logic [191:0] lhs;
      logic [191:0] rhs;
      lhs = 192'd1;
      rhs = 192'd1;
      for (int k = 0; k < 5; k++) begin
        lhs = lhs * 192'(q);
        rhs = rhs * 192'(CodeMax);
      end
      for (int k = 0; k < 11; k++) begin
        lhs = lhs * 192'd510;
        rhs = rhs * 192'(2 * b - 1);
      end
      return lhs >= rhs;
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] value);
      if (idx == RegExposure) begin
        gain = value;
      end else begin
        scale = value;
      end
    endfunction

    // Scale, saturate, apply the filmic curve, quantize and gamma encode one channel.
    function logic [7:0] tone_map(logic [31:0] sum);
      logic [63:0] prod;
      logic [63:0] x;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] q;
      prod = 64'(sum) * 64'(scale) * 64'(gain);
      x    = prod >> 24;
      if (x > 64'(XSat)) begin
        x = 64'(XSat);
      end
      num = x * (64'd251 * x + 64'd196608);
      den = x * (64'd243 * x + 64'd3866624) + (64'd14 << 32);
      if (num >= den) begin
        q = 64'(CodeMax);
      end else begin
        q = (num * 64'(CodeMax) + den / 2) / den;
      end
      return gamma_lut[q];
    endfunction

    function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
      pixel_bytes_t exp_px;
      exp_px.red   = tone_map(r);
      exp_px.green = tone_map(g);
      exp_px.blue  = tone_map(b);
      pending_q.push_back(exp_px);
    endfunction

    function void check_pixel(pixel_bytes_t got);
      pixel_bytes_t exp_px;
      if (pending_q.size() == 0) begin
        $error("unexpected output item: red %0d green %0d blue %0d",
               got.red, got.green, got.blue);
        fail_count++;
        return;
      end
      exp_px = pending_q.pop_front();
      if (got.red !== exp_px.red) begin
        $error("red_byte: expected %0d, got %0d", exp_px.red, got.red);
        fail_count++;
      end
      if (got.green !== exp_px.green) begin
        $error("green_byte: expected %0d, got %0d", exp_px.green, got.green);
        fail_count++;
      end
      if (got.blue !== exp_px.blue) begin
        $error("blue_byte: expected %0d, got %0d", exp_px.blue, got.blue);
        fail_count++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] red_sum_i;
  logic [31:0] green_sum_i;
  logic [31:0] blue_sum_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  red_byte_o;
  logic [7:0]  green_byte_o;
  logic [7:0]  blue_byte_o;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  pixel_scoreboard pixel_sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     cycle_count;

  aces_tonemap_gamma_pixel_core #(
    .GAMMA_TABLE_BITS(TableBits)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_sum_i   (red_sum_i),
    .green_sum_i (green_sum_i),
    .blue_sum_i  (blue_sum_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_byte_o  (red_byte_o),
    .green_byte_o(green_byte_o),
    .blue_byte_o (blue_byte_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Output side: check accepted items and stall at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixel_sb.check_pixel({red_byte_o, green_byte_o, blue_byte_o});
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one pixel after an optional random gap and wait for acceptance.
  task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b);
    int unsigned gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        gap++;
      end
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    red_sum_i   <= r;
    green_sum_i <= g;
    blue_sum_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pixel_sb.note_pixel(r, g, b);
  endtask

  // Wait until every expected item has arrived, then let the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixel_sb.pending_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // One register write; the write enable is dropped again before the task returns.
  task automatic write_cfg(logic [0:0] idx, logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pixel_sb.write_reg(idx, value);
    @(posedge clk_i);
  endtask

  // Random sum: a spread of magnitudes so the whole curve is covered.
  function automatic logic [31:0] rand_sum();
    if ($urandom_range(3) == 0) begin
      return $urandom();
    end
    return $urandom() >> $urandom_range(31);
  endfunction

  task automatic random_phase(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      case (k / (count / 4))
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 47; recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct = 25; recv_stall_pct = 25;
        end
      endcase
      send_pixel(rand_sum(), rand_sum(), rand_sum());
    end
  endtask

  initial begin
    logic [15:0] gain_set[6];
    logic [15:0] scale_set[6];
    pixel_sb       = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    red_sum_i      = '0;
    green_sum_i    = '0;
    blue_sum_i     = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = RegExposure;
    cfg_data_i     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pixels at reset settings: zero, full scale, around the knee.
    send_pixel(32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
    send_pixel(32'h1, 32'h0040_0000, 32'h001D_0000);
    send_pixel(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
    send_pixel(32'h0010_0000, 32'h0020_0000, 32'h7FFF_FFFF);
    send_pixel(32'h0000_0100, 32'h0000_1000, 32'h5555_5555);
    send_pixel(32'hAAAA_AAAA, 32'h01CF_0000, 32'h01D0_0000);
    drain();

    // Large exposure saturates the scaled radiance well past the curve's top.
    write_cfg(RegExposure, 16'hFFFF);
    write_cfg(RegScale, 16'hFFFF);
    send_pixel(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0100);
    send_pixel(32'h0000_0400, 32'h0000_1000, 32'h0001_0000);
    drain();

    // A zero sample scale makes every byte zero.
    write_cfg(RegScale, 16'h0000);
    send_pixel(32'hFFFF_FFFF, 32'h1234_5678, 32'h0001_0000);
    drain();

    // Zero exposure and the smallest sample scale.
    write_cfg(RegExposure, 16'h0000);
    write_cfg(RegScale, 16'h0001);
    send_pixel(32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
    drain();
    write_cfg(RegExposure, 16'h0100);
    send_pixel(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h8000_0000);
    drain();

    // Random pixels over several register settings.
    gain_set  = '{ExposureRst, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000};
    scale_set = '{ScaleRst, 16'hFFFF, 16'h0001, 16'h0000, 16'h0001, 16'h0000};
    gain_set[5]  = 16'($urandom());
    scale_set[5] = 16'($urandom());
    for (int p = 0; p < 6; p++) begin
      write_cfg(RegExposure, gain_set[p]);
      write_cfg(RegScale, scale_set[p]);
      random_phase(100);
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    if (pixel_sb.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
